@@ sv/fvec_pkg.sv @@
// Shared types and codes for the fixed-capacity vector.
package fvec_pkg;

  // Command codes carried by an input transaction.
  typedef enum logic [3:0] {
    CMD_CLEAR      = 4'd0,
    CMD_SET        = 4'd1,
    CMD_PUSH       = 4'd2,
    CMD_POP        = 4'd3,
    CMD_GET        = 4'd4,
    CMD_REM_ORD    = 4'd5,
    CMD_REM_UNORD  = 4'd6,
    CMD_ITER_RESET = 4'd7,
    CMD_NEXT       = 4'd8
  } cmd_e;

  // Status codes reported with every result.
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BOUNDS    = 2'd1,
    ST_FULL      = 2'd2,
    ST_EXHAUSTED = 2'd3
  } status_e;

  // Widest count the vector can reach (capacity up to 256).
  localparam int unsigned CmpWidth = 9;

  typedef struct packed {
    logic [3:0]  command;
    logic [7:0]  index;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] read_data;
    logic [4:0]  element_count;
    logic        has_more;
  } out_item_t;

  // Broadcast operation enables sent to every cell of the chain.
  typedef struct packed {
    logic clear;  // zero every entry
    logic wr;     // write wr_data at wr_sel
    logic shift;  // take the upper neighbor from target up to below last
    logic move;   // write the read bus at target
    logic drop;   // zero the entry at last
  } cell_ctrl_t;

endpackage

@@ sv/fvec_cell.sv @@
// One storage cell of the vector chain: holds one entry and picks its next value.
module fvec_cell #(
  parameter int unsigned IDX_W  = 4,
  parameter int unsigned ELEM_W = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic [IDX_W-1:0]      cell_idx_i,
  input  fvec_pkg::cell_ctrl_t  ctrl_i,
  input  logic [IDX_W-1:0]      wr_sel_i,
  input  logic [IDX_W-1:0]      target_i,
  input  logic [IDX_W-1:0]      last_i,
  input  logic [ELEM_W-1:0]     wr_data_i,
  input  logic [ELEM_W-1:0]     move_data_i,
  input  logic [ELEM_W-1:0]     upper_i,
  output logic [ELEM_W-1:0]     data_o
);

  logic [ELEM_W-1:0] data_d, data_q;

  // Next entry value; zeroing of the vacated last entry wins over the other moves.
  always_comb begin
    data_d = data_q;
    if (ctrl_i.clear) begin
      data_d = '0;
    end else if (ctrl_i.drop && (cell_idx_i == last_i)) begin
      data_d = '0;
    end else if (ctrl_i.shift && (cell_idx_i >= target_i) && (cell_idx_i < last_i)) begin
      data_d = upper_i;
    end else if (ctrl_i.move && (cell_idx_i == target_i)) begin
      data_d = move_data_i;
    end else if (ctrl_i.wr && (cell_idx_i == wr_sel_i)) begin
      data_d = wr_data_i;
    end
  end

  // The store is cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;

endmodule

@@ sv/fixed_capacity_vector.sv @@
// Top level of the fixed-capacity vector: command decode, iterator and the cell chain.
//
//   Channel | Direction | Handshake               | Payload
//   --------+-----------+-------------------------+---------------------------
//   in      | input     | in_valid_i / in_ready_o | in_data_i  (in_item_t)
//   out     | output    | out_valid_o/out_ready_i | out_data_o (out_item_t)
//
// Every command, ordered removal included, completes at the accepting edge: all cells
// of the chain load their next value in parallel.
// The result appears in the output register on the cycle after acceptance.
// A new transaction is taken while the result register is empty or being read.
// Reset zeroes every cell, the fill count and the iterator position.
// A stalled output holds the result and blocks the input until it is taken.
module fixed_capacity_vector #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  fvec_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output fvec_pkg::out_item_t  out_data_o
);

  localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned XW   = fvec_pkg::CmpWidth;

  logic                 accept;
  logic [CntW-1:0]      count_d, count_q;
  logic [CntW-1:0]      iter_d, iter_q;
  logic                 out_valid_q;
  fvec_pkg::out_item_t  out_d, out_q;

  fvec_pkg::cell_ctrl_t ctrl, ctrl_gated;
  logic [IdxW-1:0]      wr_sel, target, last_idx, rd_sel;
  logic [ELEM_WIDTH-1:0] wr_data, rd_data;
  logic [ELEM_WIDTH-1:0] cell_q [CAPACITY];

  logic [XW-1:0]        idx_x, cnt_x, iter_x, cap_x;
  fvec_pkg::cmd_e       cmd;

  assign cmd      = fvec_pkg::cmd_e'(in_data_i.command);
  assign idx_x    = XW'(in_data_i.index);
  assign cnt_x    = XW'(count_q);
  assign iter_x   = XW'(iter_q);
  assign cap_x    = XW'(CAPACITY);
  assign target   = in_data_i.index[IdxW-1:0];
  assign last_idx = IdxW'(count_q - CntW'(1));
  assign wr_data  = ELEM_WIDTH'(in_data_i.value);

  // Handshake: the result register parts the two sides.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Read address for the shared read bus.
  always_comb begin
    unique case (cmd)
      fvec_pkg::CMD_NEXT:      rd_sel = iter_q[IdxW-1:0];
      fvec_pkg::CMD_REM_UNORD: rd_sel = last_idx;
      default:                 rd_sel = target;
    endcase
  end

  // Read bus: AND-OR selection over the cells.
  always_comb begin
    rd_data = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_data = rd_data | (cell_q[i] & {ELEM_WIDTH{rd_sel == IdxW'(i)}});
    end
  end

  // Command decode: cell operations, counters and the result.
  always_comb begin
    ctrl                = '0;
    wr_sel              = target;
    count_d             = count_q;
    iter_d              = iter_q;
    out_d.status        = fvec_pkg::ST_OK;
    out_d.read_data     = '0;
    unique case (cmd)
      fvec_pkg::CMD_CLEAR: begin
        ctrl.clear = 1'b1;
        count_d    = '0;
      end
      fvec_pkg::CMD_SET: begin
        if (idx_x >= cap_x) begin
          out_d.status = fvec_pkg::ST_BOUNDS;
        end else begin
          ctrl.wr = 1'b1;
          if (idx_x >= cnt_x) begin
            count_d = CntW'(idx_x + XW'(1));
          end
        end
      end
      fvec_pkg::CMD_PUSH: begin
        if (cnt_x >= cap_x) begin
          out_d.status = fvec_pkg::ST_FULL;
        end else begin
          ctrl.wr = 1'b1;
          wr_sel  = count_q[IdxW-1:0];
          count_d = count_q + CntW'(1);
        end
      end
      fvec_pkg::CMD_POP: begin
        if (count_q != '0) begin
          ctrl.drop = 1'b1;
          count_d   = count_q - CntW'(1);
        end
      end
      fvec_pkg::CMD_GET: begin
        if (idx_x >= cap_x) begin
          out_d.status = fvec_pkg::ST_BOUNDS;
        end else begin
          out_d.read_data = 32'(rd_data);
        end
      end
      fvec_pkg::CMD_REM_ORD: begin
        if (idx_x >= cnt_x) begin
          out_d.status = fvec_pkg::ST_BOUNDS;
        end else begin
          ctrl.shift = 1'b1;
          ctrl.drop  = 1'b1;
          count_d    = count_q - CntW'(1);
        end
      end
      fvec_pkg::CMD_REM_UNORD: begin
        if (idx_x >= cnt_x) begin
          out_d.status = fvec_pkg::ST_BOUNDS;
        end else begin
          ctrl.move = 1'b1;
          ctrl.drop = 1'b1;
          count_d   = count_q - CntW'(1);
        end
      end
      fvec_pkg::CMD_ITER_RESET: begin
        iter_d = '0;
      end
      fvec_pkg::CMD_NEXT: begin
        if ((iter_x < cnt_x) && (iter_x < cap_x)) begin
          out_d.read_data = 32'(rd_data);
          iter_d          = iter_q + CntW'(1);
        end else begin
          out_d.status = fvec_pkg::ST_EXHAUSTED;
        end
      end
      default: begin
        // Undefined commands change nothing.
      end
    endcase
    out_d.element_count = 5'(count_d);
    out_d.has_more      = (iter_d < count_d);
  end

  assign ctrl_gated = accept ? ctrl : '0;

  // The chain of cells; each takes its upper neighbor for ordered removal.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ELEM_WIDTH-1:0] upper;
    if (g == CAPACITY - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid
      assign upper = cell_q[g+1];
    end
    fvec_cell #(
      .IDX_W  (IdxW),
      .ELEM_W (ELEM_WIDTH)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cell_idx_i  (IdxW'(g)),
      .ctrl_i      (ctrl_gated),
      .wr_sel_i    (wr_sel),
      .target_i    (target),
      .last_i      (last_idx),
      .wr_data_i   (wr_data),
      .move_data_i (rd_data),
      .upper_i     (upper),
      .data_o      (cell_q[g])
    );
  end

  // Control registers: counters and the result valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        iter_q      <= iter_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  // The fill count never passes the capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    XW'(count_q) <= XW'(CAPACITY))
    else $error("fill count above capacity");

  // A clear leaves an empty vector.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd == fvec_pkg::CMD_CLEAR) |=> count_q == '0)
    else $error("clear did not empty the vector");

  // A push that fits grows the count by one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd == fvec_pkg::CMD_PUSH) && (cnt_x < cap_x)
    |=> count_q == $past(count_q) + CntW'(1))
    else $error("push did not grow the count");

  // A held result reports the current fill count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> out_q.element_count == 5'(count_q))
    else $error("result count disagrees with fill count");

endmodule
